[rtl/core/itd_pkg.sv]
package itd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_RADIX_DEF   = 16;
  localparam int unsigned VALUE_MAX_W     = 32;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned RADIX_W         = 5;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned APB_DATA_W      = 64;
  localparam int unsigned APB_ADDR_W      = 5;
  localparam int unsigned REG_IDX_W       = 2;

  localparam logic [REG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2d;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

  typedef struct packed {
    logic                   start;
    logic                   load;
    logic [VALUE_MAX_W-1:0] mag;
  } itd_div_ctrl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               zero;
  } itd_div_stat_t;

endpackage

[rtl/core/itd_in_if.sv]
interface itd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

[rtl/core/itd_out_if.sv]
interface itd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        last;
  logic [31:0] char_count;

  modport source (output valid, output out_char, output last, output char_count, input ready);
  modport sink   (input valid, input out_char, input last, input char_count, output ready);
endinterface

[rtl/core/itd_digit_div.sv]
module itd_digit_div
  import itd_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itd_div_ctrl_t      ctrl_i,
  input  logic [RADIX_W-1:0] radix_i,
  output itd_div_stat_t      stat_o
);

  localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic [VALUE_WIDTH-1:0] mag_q;
  logic [DIGIT_W-1:0]     rem_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q, done_q, nz_q;
  logic [DIGIT_W-1:0]     digit_q;
  logic                   zero_q;

  logic [RADIX_W-1:0] trial;
  logic               ge;
  logic [RADIX_W-1:0] rem_next;

  // one quotient bit per cycle, remainder stays below the radix
  assign trial    = {rem_q, mag_q[VALUE_WIDTH-1]};
  assign ge       = (trial >= radix_i);
  assign rem_next = ge ? (trial - radix_i) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      nz_q  <= 1'b0;
      if (ctrl_i.load) begin
        mag_q <= ctrl_i.mag[VALUE_WIDTH-1:0];
      end
    end else if (busy_q) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], ge};
      rem_q <= rem_next[DIGIT_W-1:0];
      nz_q  <= nz_q | ge;
      if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
        digit_q <= rem_next[DIGIT_W-1:0];
        zero_q  <= !(nz_q | ge);
      end
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign stat_o.digit = digit_q;
  assign stat_o.zero  = zero_q;

endmodule

[rtl/core/integer_to_radix_digits_unit.sv]
// Integer to radix text converter.
// in_i carries one request: func (0 signed, 1 unsigned) and value. out_o
// carries one character per transfer, most significant digit first, with a
// leading '-' for a negative signed value, last on the final character and
// a running char_count that is one on the first character after reset.
// Radix and the 16-entry digit alphabet are set over the APB port
// (radix at 0x00, digits 0-7 at 0x08, digits 8-15 at 0x10).
// Each digit comes from the bit-serial restoring divider; once all digits
// are in, the characters (the digits and any '-') leave through the output
// register at one per cycle while the receiver holds out_o.ready high.
// in_i.ready is high only while no request is in work; the next request is
// taken while the final character still waits in the output register.
// A stalled receiver holds the output register and pauses the emission.
// Reset clears the character count, empties the output and restores
// radix 10 with an all-zero alphabet.
module integer_to_radix_digits_unit
  import itd_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_RADIX   = MAX_RADIX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  itd_in_if.sink                in_i,
  itd_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned N_W   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned IDX_W = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [63:0]        chars_low_q, chars_high_q;

  logic [DIGIT_W-1:0] stack_q [VALUE_WIDTH];
  logic [N_W-1:0]     n_q, n_d;
  logic               minus_q, minus_d, neg_q;
  logic [COUNT_W-1:0] count_q;

  logic               ov_q;
  logic [CHAR_W-1:0]  och_q;
  logic               olast_q;
  logic [COUNT_W-1:0] ocnt_q;

  itd_div_ctrl_t div_ctrl;
  itd_div_stat_t div_stat;

  logic [RADIX_W-1:0]     eff_radix;
  logic [VALUE_WIDTH-1:0] v_in;
  logic                   neg_in;
  logic                   in_acc, can_load, emit, wr;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [N_W-1:0]         n_inc, n_dec;
  logic [127:0]           alphabet;
  logic [DIGIT_W-1:0]     rd_digit;
  logic [CHAR_W-1:0]      char_d;
  logic                   last_d;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= RADIX_RESET;
      chars_low_q  <= '0;
      chars_high_q <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_RADIX:      radix_q      <= pwdata[RADIX_W-1:0];
        REG_CHARS_LOW:  chars_low_q  <= pwdata;
        REG_CHARS_HIGH: chars_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIX:      prdata = {{(APB_DATA_W-RADIX_W){1'b0}}, radix_q};
      REG_CHARS_LOW:  prdata = chars_low_q;
      REG_CHARS_HIGH: prdata = chars_high_q;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    eff_radix = radix_q;
    if (radix_q < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_q > RADIX_W'(MAX_RADIX)) begin
      eff_radix = RADIX_W'(MAX_RADIX);
    end
  end

  // request intake
  assign v_in     = in_i.value[VALUE_WIDTH-1:0];
  assign neg_in   = !in_i.func && v_in[VALUE_WIDTH-1];
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc   = in_i.valid && in_i.ready;

  assign can_load = !ov_q || out_o.ready;
  assign emit     = (state_q == S_EMIT) && can_load;
  assign n_inc    = n_q + 1'b1;
  assign n_dec    = n_q - 1'b1;
  assign alphabet = {chars_high_q, chars_low_q};
  assign rd_digit = stack_q[n_dec[IDX_W-1:0]];

  always_comb begin
    if (minus_q) begin
      char_d = MINUS_CHAR;
      last_d = 1'b0;
    end else begin
      char_d = alphabet[rd_digit*CHAR_W +: CHAR_W];
      last_d = (n_q == N_W'(1));
    end
  end

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    minus_d      = minus_q;
    div_ctrl     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          div_ctrl.start = 1'b1;
          div_ctrl.load  = 1'b1;
          div_ctrl.mag   = VALUE_MAX_W'(neg_in ? (~v_in + 1'b1) : v_in);
          n_d            = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          n_d = n_inc;
          if (div_stat.zero || n_inc == N_W'(VALUE_WIDTH)) begin
            minus_d = neg_q;
            state_d = S_EMIT;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (emit) begin
          if (minus_q) begin
            minus_d = 1'b0;
          end else begin
            n_d = n_dec;
            if (n_q == N_W'(1)) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      minus_q <= 1'b0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      minus_q <= minus_d;
      if (emit) begin
        ov_q    <= 1'b1;
        count_q <= count_q + 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q <= neg_in;
    end
    if ((state_q == S_DIV) && div_stat.done) begin
      stack_q[n_q[IDX_W-1:0]] <= div_stat.digit;
    end
    if (emit) begin
      och_q   <= char_d;
      olast_q <= last_d;
      ocnt_q  <= count_q + 1'b1;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_char   = och_q;
  assign out_o.last       = olast_q;
  assign out_o.char_count = ocnt_q;

  itd_digit_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .radix_i (eff_radix),
    .stat_o  (div_stat)
  );

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  a_emit_has_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (n_q != '0))
    else $error("emit phase with an empty digit stack");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(VALUE_WIDTH))
    else $error("digit count beyond value width");

  a_div_idle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && !div_stat.done |-> div_stat.busy || $past(div_ctrl.start))
    else $error("divide phase with the divider stopped");

endmodule
